// ===== rtl/tflc_pkg.sv =====
// Shared types and codes for the three-floor lift controller.
`timescale 1ns / 1ps
package tflc_pkg;

    // floor codes held in the state
    localparam logic [1:0] FLOOR_NONE = 2'd0;
    localparam logic [1:0] FLOOR_1    = 2'd1;
    localparam logic [1:0] FLOOR_2    = 2'd2;
    localparam logic [1:0] FLOOR_3    = 2'd3;

    // run modes
    localparam logic [1:0] MODE_1 = 2'd1;
    localparam logic [1:0] MODE_2 = 2'd2;
    localparam logic [1:0] MODE_3 = 2'd3;

    // display line codes
    localparam logic [1:0] DISP_F1 = 2'd2;
    localparam logic [1:0] DISP_F2 = 2'd1;
    localparam logic [1:0] DISP_F3 = 2'd3;

    // lamp and hall button bit positions
    localparam int LAMP_F3    = 0;
    localparam int LAMP_F2_UP = 1;
    localparam int LAMP_F2_DN = 2;
    localparam int LAMP_F1    = 3;

    // car button bit positions
    localparam int CAR_F3 = 0;
    localparam int CAR_F2 = 1;
    localparam int CAR_F1 = 2;

    // request bit positions, one per floor
    localparam int REQ_F1 = 0;
    localparam int REQ_F2 = 1;
    localparam int REQ_F3 = 2;

    typedef struct packed {
        logic [2:0] floor_sensors;
        logic [2:0] mode_switches;
        logic [3:0] hall_buttons;
        logic [2:0] car_buttons;
    } t_poll;

    typedef struct packed {
        logic [1:0] current_floor;
        logic [1:0] run_mode;
        logic [2:0] up_requests;
        logic [2:0] down_requests;
        logic [3:0] call_lamps;
        logic       motor_up;
        logic       motor_down;
        logic [1:0] display_code;
    } t_lift_state;

    localparam t_lift_state STATE_RESET = '0;

endpackage

// ===== rtl/tflc_if.sv =====
// Valid/ready channel interfaces for pin polls and controller results.
`timescale 1ns / 1ps
interface tflc_poll_if;
    logic       valid;
    logic       ready;
    logic [2:0] floor_sensors;
    logic [2:0] mode_switches;
    logic [3:0] hall_buttons;
    logic [2:0] car_buttons;

    modport source (
        output valid, floor_sensors, mode_switches, hall_buttons, car_buttons,
        input  ready
    );
    modport sink (
        input  valid, floor_sensors, mode_switches, hall_buttons, car_buttons,
        output ready
    );
endinterface

interface tflc_result_if;
    logic       valid;
    logic       ready;
    logic       drive_up;
    logic       drive_down;
    logic [3:0] lamps_out;
    logic [1:0] floor_indicator;

    modport source (
        output valid, drive_up, drive_down, lamps_out, floor_indicator,
        input  ready
    );
    modport sink (
        input  valid, drive_up, drive_down, lamps_out, floor_indicator,
        output ready
    );
endinterface

// ===== rtl/tflc_step.sv =====
// Next-state logic for one pin poll of the lift controller.
`timescale 1ns / 1ps
module tflc_step
    import tflc_pkg::*;
(
    input  t_lift_state i_state,
    input  t_poll       i_poll,
    output t_lift_state o_state
);

    always_comb begin
        t_lift_state s;
        logic [1:0]  chosen;
        logic        go_up;
        logic        go_dn;

        s      = i_state;
        chosen = FLOOR_NONE;

        if (i_poll.floor_sensors[2])      s.current_floor = FLOOR_3;
        else if (i_poll.floor_sensors[1]) s.current_floor = FLOOR_2;
        else if (i_poll.floor_sensors[0]) s.current_floor = FLOOR_1;

        if (i_poll.mode_switches[0])      s.run_mode = MODE_1;
        else if (i_poll.mode_switches[1]) s.run_mode = MODE_2;
        else if (i_poll.mode_switches[2]) s.run_mode = MODE_3;

        // highest pressed button picks the floor; a hall press lights its lamp unless the car is at that floor
        if (i_poll.hall_buttons[LAMP_F3] || i_poll.car_buttons[CAR_F3]) begin
            chosen = FLOOR_3;
            if (s.current_floor != FLOOR_3 && i_poll.hall_buttons[LAMP_F3])
                s.call_lamps[LAMP_F3] = 1'b1;
        end else if (i_poll.hall_buttons[LAMP_F2_UP] || i_poll.hall_buttons[LAMP_F2_DN]
                     || i_poll.car_buttons[CAR_F2]) begin
            chosen = FLOOR_2;
            if (s.current_floor != FLOOR_2) begin
                if (i_poll.hall_buttons[LAMP_F2_UP])
                    s.call_lamps[LAMP_F2_UP] = 1'b1;
                else if (i_poll.hall_buttons[LAMP_F2_DN])
                    s.call_lamps[LAMP_F2_DN] = 1'b1;
            end
        end else if (i_poll.hall_buttons[LAMP_F1] || i_poll.car_buttons[CAR_F1]) begin
            chosen = FLOOR_1;
            if (s.current_floor != FLOOR_1 && i_poll.hall_buttons[LAMP_F1])
                s.call_lamps[LAMP_F1] = 1'b1;
        end

        // arrival clearing; floor 2 only in the travel direction
        go_up = s.motor_up && !s.motor_down && s.current_floor != FLOOR_3;
        go_dn = !s.motor_up && s.motor_down && s.current_floor != FLOOR_1;
        if (go_up && s.current_floor == FLOOR_2) begin
            s.up_requests[REQ_F2]    = 1'b0;
            s.call_lamps[LAMP_F2_UP] = 1'b0;
        end else if (go_dn && s.current_floor == FLOOR_2) begin
            s.down_requests[REQ_F2]  = 1'b0;
            s.call_lamps[LAMP_F2_DN] = 1'b0;
        end else if (s.current_floor == FLOOR_1) begin
            s.up_requests[REQ_F1]   = 1'b0;
            s.down_requests[REQ_F1] = 1'b0;
            s.call_lamps[LAMP_F1]   = 1'b0;
        end else if (s.current_floor == FLOOR_3) begin
            s.up_requests[REQ_F3]   = 1'b0;
            s.down_requests[REQ_F3] = 1'b0;
            s.call_lamps[LAMP_F3]   = 1'b0;
        end

        if ((s.up_requests | s.down_requests) == 3'b000) begin
            s.motor_up   = 1'b0;
            s.motor_down = 1'b0;
        end

        // unknown floor (code zero) is below every floor, so it requests up
        if (chosen != FLOOR_NONE && s.current_floor != chosen) begin
            if (s.current_floor > chosen) begin
                unique case (chosen)
                    FLOOR_1: s.down_requests[REQ_F1] = 1'b1;
                    FLOOR_2: s.down_requests[REQ_F2] = 1'b1;
                    default: s.down_requests[REQ_F3] = 1'b1;
                endcase
            end else begin
                unique case (chosen)
                    FLOOR_1: s.up_requests[REQ_F1] = 1'b1;
                    FLOOR_2: s.up_requests[REQ_F2] = 1'b1;
                    default: s.up_requests[REQ_F3] = 1'b1;
                endcase
            end
        end

        if (s.call_lamps[LAMP_F2_UP]) s.up_requests[REQ_F2]   = 1'b1;
        if (s.call_lamps[LAMP_F2_DN]) s.down_requests[REQ_F2] = 1'b1;

        // start rules when idle and not in mode 3
        go_up = s.motor_up && !s.motor_down && s.current_floor != FLOOR_3;
        go_dn = !s.motor_up && s.motor_down && s.current_floor != FLOOR_1;
        if (!go_up && !go_dn && s.run_mode != MODE_3) begin
            unique case (s.current_floor)
                FLOOR_1: begin
                    if (s.up_requests[REQ_F2] || s.up_requests[REQ_F3]) begin
                        s.motor_up   = 1'b1;
                        s.motor_down = 1'b0;
                    end
                end
                FLOOR_2: begin
                    s.call_lamps[LAMP_F2_UP] = 1'b0;
                    s.call_lamps[LAMP_F2_DN] = 1'b0;
                    if (s.up_requests[REQ_F3]) begin
                        s.motor_up   = 1'b1;
                        s.motor_down = 1'b0;
                    end else if (s.down_requests[REQ_F1]) begin
                        s.motor_up   = 1'b0;
                        s.motor_down = 1'b1;
                    end
                end
                FLOOR_3: begin
                    if (s.down_requests[REQ_F1] || s.down_requests[REQ_F2]) begin
                        s.motor_up   = 1'b0;
                        s.motor_down = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (i_poll.floor_sensors[2])      s.display_code = DISP_F3;
        else if (i_poll.floor_sensors[1]) s.display_code = DISP_F2;
        else if (i_poll.floor_sensors[0]) s.display_code = DISP_F1;

        o_state = s;
    end

endmodule

// ===== rtl/three_floor_lift_controller_unit.sv =====
// Top level of the three-floor lift controller: input register, step, result register.
// An accepted poll waits in the input register until the result register can take its result beat.
// Throughput: one poll per cycle unless the result channel stalls; the state updates in one pass of the step logic.
// A stalled result holds the next poll in the input register; ready drops only then.
// Reset (synchronous, active low): floor unknown, mode zero, no requests, lamps off,
// motor stopped, display zero, both channels empty.
`timescale 1ns / 1ps
module three_floor_lift_controller_unit
    import tflc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tflc_poll_if.sink            i_req,
    tflc_result_if.source        o_rsp
);

    logic        r_in_valid;
    t_poll       r_poll;
    logic        r_out_valid;
    t_lift_state r_state;
    t_lift_state n_state;
    logic        advance;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    tflc_step u_step (
        .i_state (r_state),
        .i_poll  (r_poll),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (i_req.ready) r_in_valid <= i_req.valid;
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_poll.floor_sensors <= i_req.floor_sensors;
            r_poll.mode_switches <= i_req.mode_switches;
            r_poll.hall_buttons  <= i_req.hall_buttons;
            r_poll.car_buttons   <= i_req.car_buttons;
        end
    end

    // the result beat is the state just written
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.drive_up        = r_state.motor_up;
    assign o_rsp.drive_down      = r_state.motor_down;
    assign o_rsp.lamps_out       = r_state.call_lamps;
    assign o_rsp.floor_indicator = r_state.display_code;

    a_motor_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state.motor_up && r_state.motor_down))
        else $error("motor driven up and down at once");

    a_no_start_unknown_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.current_floor == FLOOR_NONE) |-> (!r_state.motor_up && !r_state.motor_down))
        else $error("motor running with floor unknown");

    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_req.ready)
        else $error("input stalled with empty result register");

    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed poll produced no result beat");

endmodule
